FILE: sv/rain_shield_motor_controller_assert.svh
// ----------------------------------------------------------------------------
// Rain shield motor controller assertion macros
// Short forms for the concurrent checks on the controller's ports.
// ----------------------------------------------------------------------------
`ifndef RAIN_SHIELD_MOTOR_CONTROLLER_ASSERT_SVH
`define RAIN_SHIELD_MOTOR_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rsmc_pkg.sv
// ----------------------------------------------------------------------------
// Rain shield motor controller package
// Codes, state and work types shared by the controller, its divider and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rsmc_pkg;

  localparam logic [13:0] POS_FULL   = 14'd10000;
  localparam int          DIV_STEPS  = 33;
  localparam int          DIV_CNT_W  = $clog2(DIV_STEPS);

  // Item kinds
  localparam logic [1:0] FN_TICK  = 2'd0;
  localparam logic [1:0] FN_CMD   = 2'd1;
  localparam logic [1:0] FN_FAULT = 2'd2;

  // Motion codes
  localparam logic [1:0] MO_STOP    = 2'd0;
  localparam logic [1:0] MO_DEPLOY  = 2'd1;
  localparam logic [1:0] MO_RETRACT = 2'd2;
  localparam logic [1:0] MO_DEAD    = 2'd3;

  // Shield position codes
  localparam logic [1:0] SH_UNKNOWN   = 2'd0;
  localparam logic [1:0] SH_RETRACTED = 2'd1;
  localparam logic [1:0] SH_DEPLOYED  = 2'd2;
  localparam logic [1:0] SH_PARTWAY   = 2'd3;

  // Confidence codes
  localparam logic [1:0] CF_UNKNOWN = 2'd0;
  localparam logic [1:0] CF_EST     = 2'd1;
  localparam logic [1:0] CF_USER    = 2'd2;
  localparam logic [1:0] CF_LIMIT   = 2'd3;

  // Rain codes
  localparam logic [1:0] RN_UNKNOWN = 2'd0;
  localparam logic [1:0] RN_DRY     = 2'd1;
  localparam logic [1:0] RN_WET     = 2'd2;

  // Command result codes
  localparam logic [2:0] RS_IDLE     = 3'd0;
  localparam logic [2:0] RS_ACCEPTED = 3'd1;
  localparam logic [2:0] RS_MODE     = 3'd2;
  localparam logic [2:0] RS_RAIN     = 3'd3;
  localparam logic [2:0] RS_FAULT    = 3'd4;
  localparam logic [2:0] RS_DUP      = 3'd5;
  localparam logic [2:0] RS_INVALID  = 3'd6;
  localparam logic [2:0] RS_STATE    = 3'd7;

  // Command phase codes
  localparam logic [2:0] PH_NONE      = 3'd0;
  localparam logic [2:0] PH_ACCEPTED  = 3'd1;
  localparam logic [2:0] PH_STARTED   = 3'd2;
  localparam logic [2:0] PH_COMPLETED = 3'd3;
  localparam logic [2:0] PH_STOPPED   = 3'd4;
  localparam logic [2:0] PH_REJECTED  = 3'd5;
  localparam logic [2:0] PH_FAULT     = 3'd6;

  // Command codes
  localparam logic [3:0] CM_INVALID   = 4'd0;
  localparam logic [3:0] CM_AUTO      = 4'd1;
  localparam logic [3:0] CM_MANUAL    = 4'd2;
  localparam logic [3:0] CM_DEPLOY    = 4'd3;
  localparam logic [3:0] CM_RETRACT   = 4'd4;
  localparam logic [3:0] CM_STOP      = 4'd5;
  localparam logic [3:0] CM_RESET     = 4'd6;
  localparam logic [3:0] CM_CAL_DEP   = 4'd7;
  localparam logic [3:0] CM_CAL_RET   = 4'd8;

  // Fault codes
  localparam logic [2:0] FL_NONE     = 3'd0;
  localparam logic [2:0] FL_TIMEOUT  = 3'd1;
  localparam logic [2:0] FL_CONFLICT = 3'd2;
  localparam logic [2:0] FL_STORAGE  = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_WET   = 3'd0;
  localparam logic [2:0] REG_DRY   = 3'd1;
  localparam logic [2:0] REG_DEAD  = 3'd2;
  localparam logic [2:0] REG_FULL  = 3'd3;
  localparam logic [2:0] REG_MAX   = 3'd4;
  localparam logic [2:0] REG_LIMIT = 3'd5;

  typedef struct packed {
    logic        busy;
    logic        done;
  } div_stat_t;

  typedef struct packed {
    logic        mode_auto;
    logic [1:0]  rain_conf;
    logic        rain_cand;
    logic [31:0] rain_since;
    logic [1:0]  shield;
    logic [1:0]  conf;
    logic [1:0]  motion;
    logic [1:0]  pend;
    logic [2:0]  fault;
    logic        latched;
    logic        est_ok;
    logic [13:0] pos_now;
    logic [13:0] pos_start;
    logic [13:0] pos_goal;
    logic [18:0] move_dur;
    logic [31:0] move_start;
    logic [31:0] dead_start;
    logic [31:0] motion_req;
    logic [31:0] last_req;
    logic [2:0]  last_res;
    logic [2:0]  phase;
  } st_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic        wet;
    logic        rl;
    logic        dl;
    logic [3:0]  code;
    logic [31:0] rid;
    logic [2:0]  fc;
    logic        lim_en;
    logic        rain_ok;
    logic        dead_ok0;
    logic        dead_zero;
    logic        run_ge_max;
    logic        run_ge_dur;
    logic [13:0] e0;
    logic [18:0] full;
  } ctx_t;

  typedef struct packed {
    st_t         s;
    logic        started;
    logic        newmove;
    logic        dur_div;
    logic [2:0]  res;
    logic [2:0]  ph;
    logic        taken;
  } wk_t;

endpackage

`default_nettype wire

FILE: sv/rsmc_div.sv
// ----------------------------------------------------------------------------
// Rain shield scaled divider
// Computes floor(mul_a * mul_b / den) with one multiply and a restoring loop.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmc_div
  import rsmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [18:0] mul_a,
  input  wire logic [13:0] mul_b,
  input  wire logic [18:0] den,
  output logic      [18:0] quo,
  output div_stat_t        stat
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_RUN  = 3'b100
  } dstate_t;

  dstate_t              dstate;
  logic [18:0]          a_r;
  logic [13:0]          b_r;
  logic [18:0]          den_r;
  logic [32:0]          pq;
  logic [19:0]          rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [19:0]          trial;
  logic                 ge;

  // Shift one dividend bit into the remainder and subtract where it fits.
  assign trial = {rem[18:0], pq[32]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            dstate <= D_MUL;
          end
        end
        D_MUL: begin
          cnt    <= '0;
          dstate <= D_RUN;
        end
        D_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            dstate <= D_IDLE;
            done   <= 1'b1;
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dstate == D_IDLE && start) begin
      a_r   <= mul_a;
      b_r   <= mul_b;
      den_r <= den;
    end
    if (dstate == D_MUL) begin
      pq  <= {14'd0, a_r} * {19'd0, b_r};
      rem <= '0;
    end else if (dstate == D_RUN) begin
      rem <= ge ? trial - {1'b0, den_r} : trial;
      pq  <= {pq[31:0], ge};
    end
  end

  assign quo       = pq[18:0];
  assign stat.busy = dstate != D_IDLE;
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: sv/rain_shield_motor_controller.sv
// ----------------------------------------------------------------------------
// Rain shield motor controller
// Rain debounce, shield motor sequencing and linear position estimate.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Carries
//   s_*       in         s_tvalid / s_tready      one tick, command or fault item
//   m_*       out        m_tvalid / m_tready      one status item per input item
//   APB       in/out     psel, penable, pwrite    six configuration registers
//
// An item that needs no division passes straight through the sequencer;
// an item may need the running position estimate and a new move duration
// divided, in that order. Both divisions use the one shared 33-step
// restoring divider. s_tready is high only while the sequencer is idle. A
// finished item waits in the output register, so the next item is accepted
// while it is not yet taken. Reset is synchronous and returns the sequencer,
// the shield state, the output valid and the registers to their defaults.
//
`default_nettype none

module rain_shield_motor_controller
  import rsmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // now_ms[31:0], rain_wet[32], retracted_limit[33], deployed_limit[34],
  // command_code[38:35], request_id[70:39], fault_code[73:71], zero fill
  input  wire logic [79:0] s_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_tuser,
  // Result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cmd_result[2:0], cmd_phase[5:3], cmd_taken[6], motion_state[8:7],
  // shield_state[10:9], confidence[12:11], auto_mode[13], rain_state[15:14],
  // fault_state[18:16], position[32:19], position_valid[33],
  // stop_latched[34], zero fill
  output logic      [39:0] m_tdata,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // --------------------------------------------------------------------------
  // Model of one item as plain selection logic. Every time compare and the
  // position division were done beforehand; the steps below only choose.
  // --------------------------------------------------------------------------
  function automatic logic is_driving(logic [1:0] m);
    return m == MO_DEPLOY || m == MO_RETRACT;
  endfunction

  function automatic logic own_req(st_t s);
    return s.motion_req != '0 && s.motion_req == s.last_req;
  endfunction

  function automatic logic at_limit(logic [1:0] target, ctx_t c);
    return c.lim_en && ((target == SH_DEPLOYED && c.dl) || (target == SH_RETRACTED && c.rl));
  endfunction

  // A drive started during this item has run for zero time, so it still
  // sits at its start point.
  function automatic wk_t f_est(wk_t w, ctx_t c);
    if (is_driving(w.s.motion)) begin
      w.s.pos_now = w.started ? w.s.pos_start : c.e0;
      w.s.est_ok  = 1'b1;
      w.s.conf    = CF_EST;
    end
    return w;
  endfunction

  function automatic wk_t f_halt_at(wk_t w, logic [1:0] target, logic [1:0] cf);
    w.s.motion  = MO_STOP;
    w.s.pend    = SH_UNKNOWN;
    w.s.shield  = target;
    w.s.conf    = cf;
    w.s.pos_now = (target == SH_DEPLOYED) ? POS_FULL : '0;
    w.s.est_ok  = 1'b1;
    if (own_req(w.s)) begin
      w.s.phase = PH_COMPLETED;
    end
    w.s.motion_req = '0;
    return w;
  endfunction

  function automatic wk_t f_halt_partway(wk_t w, ctx_t c);
    w = f_est(w, c);
    if (w.s.motion != MO_STOP) begin
      w.s.shield = SH_PARTWAY;
    end
    w.s.motion     = MO_STOP;
    w.s.pend       = SH_UNKNOWN;
    w.s.motion_req = '0;
    if (!w.s.est_ok) begin
      w.s.conf = CF_UNKNOWN;
    end
    return w;
  endfunction

  function automatic wk_t f_fault(wk_t w, logic [2:0] f, ctx_t c);
    w = f_est(w, c);
    if (w.s.motion != MO_STOP) begin
      w.s.shield = SH_PARTWAY;
    end
    w.s.motion  = MO_STOP;
    w.s.pend    = SH_UNKNOWN;
    w.s.fault   = f;
    w.s.latched = 1'b1;
    if (own_req(w.s)) begin
      w.s.phase = PH_FAULT;
    end
    w.s.motion_req = '0;
    return w;
  endfunction

  function automatic wk_t f_move_to(wk_t w, logic [1:0] target, logic [31:0] rid, ctx_t c);
    logic mine;
    mine = rid != '0 && rid == w.s.last_req;
    w = f_est(w, c);
    priority if (at_limit(target, c)) begin
      w = f_halt_at(w, target, CF_LIMIT);
      if (mine) begin
        w.s.phase = PH_COMPLETED;
      end
    end else if (w.s.motion == MO_STOP && w.s.shield == target) begin
      if (mine) begin
        w.s.phase = PH_COMPLETED;
      end
    end else if ((w.s.motion == MO_DEPLOY && target == SH_DEPLOYED) ||
                 (w.s.motion == MO_RETRACT && target == SH_RETRACTED)) begin
      w.s.motion_req = rid;
      if (mine) begin
        w.s.phase = PH_STARTED;
      end
    end else if (w.s.motion == MO_DEAD && w.s.pend == target) begin
      if (rid != '0) begin
        w.s.motion_req = rid;
      end
    end else begin
      // New move: with a valid estimate, the duration division runs after this item's logic.
      w.s.pend       = target;
      w.s.motion_req = rid;
      w.s.pos_start  = w.s.est_ok ? w.s.pos_now :
                       ((target == SH_DEPLOYED) ? 14'd0 : POS_FULL);
      w.s.pos_goal   = (target == SH_DEPLOYED) ? POS_FULL : '0;
      w.newmove      = 1'b1;
      w.dur_div      = w.s.est_ok;
      if (!w.s.est_ok) begin
        w.s.move_dur = (c.full == '0) ? 19'd1 : c.full;
      end
      w.s.motion     = MO_DEAD;
      w.s.dead_start = c.now;
      w.s.shield     = SH_PARTWAY;
      w.s.conf       = w.s.est_ok ? CF_EST : CF_UNKNOWN;
    end
    return w;
  endfunction

  function automatic wk_t f_motion(wk_t w, ctx_t c);
    logic [1:0] target;
    logic       dead_ok;
    target  = (w.s.motion == MO_DEPLOY) ? SH_DEPLOYED : SH_RETRACTED;
    dead_ok = w.newmove ? c.dead_zero : c.dead_ok0;
    priority if (w.s.fault != FL_NONE) begin
      w = w;
    end else if (c.lim_en && c.rl && c.dl) begin
      w = f_fault(w, FL_CONFLICT, c);
    end else if (w.s.motion == MO_DEAD) begin
      if (at_limit(w.s.pend, c)) begin
        w = f_halt_at(w, w.s.pend, CF_LIMIT);
      end else if (dead_ok && (w.s.pend == SH_RETRACTED || w.s.pend == SH_DEPLOYED)) begin
        w.s.motion     = (w.s.pend == SH_DEPLOYED) ? MO_DEPLOY : MO_RETRACT;
        w.s.move_start = c.now;
        w.s.shield     = SH_PARTWAY;
        w.started      = 1'b1;
        if (own_req(w.s)) begin
          w.s.phase = PH_STARTED;
        end
      end
    end else if (is_driving(w.s.motion)) begin
      w = f_est(w, c);
      priority if (at_limit(target, c)) begin
        w = f_halt_at(w, target, CF_LIMIT);
      end else if (c.run_ge_max) begin
        w = f_fault(w, FL_TIMEOUT, c);
      end else if (!c.lim_en && c.run_ge_dur) begin
        w = f_halt_at(w, target, CF_EST);
      end else begin
        w = w;
      end
    end else begin
      w = w;
    end
    return w;
  endfunction

  function automatic wk_t f_auto(wk_t w, ctx_t c);
    if (w.s.mode_auto && !w.s.latched && w.s.fault == FL_NONE) begin
      if (w.s.rain_conf == RN_WET) begin
        if (w.s.shield != SH_DEPLOYED || w.s.motion == MO_RETRACT ||
            (w.s.motion == MO_DEAD && w.s.pend == SH_RETRACTED)) begin
          w = f_move_to(w, SH_DEPLOYED, '0, c);
        end
      end else if (w.s.rain_conf == RN_DRY && w.s.est_ok && w.s.shield != SH_RETRACTED) begin
        w = f_move_to(w, SH_RETRACTED, '0, c);
      end
    end
    return w;
  endfunction

  function automatic wk_t f_answer(wk_t w, logic [2:0] res, logic [2:0] ph, logic tk);
    w.s.last_res = res;
    w.s.phase    = ph;
    w.res        = res;
    w.ph         = ph;
    w.taken      = tk;
    return w;
  endfunction

  function automatic wk_t f_tick(wk_t w, ctx_t c);
    logic going_in;
    if (c.wet != w.s.rain_cand) begin
      w.s.rain_cand  = c.wet;
      w.s.rain_since = c.now;
    end else if (c.rain_ok) begin
      w.s.rain_conf = w.s.rain_cand ? RN_WET : RN_DRY;
    end
    going_in = w.s.motion == MO_RETRACT || (w.s.motion == MO_DEAD && w.s.pend == SH_RETRACTED);
    if (w.s.rain_conf == RN_WET && going_in) begin
      if (own_req(w.s)) begin
        w.s.phase = PH_STOPPED;
      end
      w = f_move_to(w, SH_DEPLOYED, '0, c);
    end
    w = f_motion(w, c);
    w = f_auto(w, c);
    return w;
  endfunction

  function automatic wk_t f_command(wk_t w, ctx_t c);
    logic [3:0] code;
    code = (c.code > CM_CAL_RET) ? CM_INVALID : c.code;
    priority if (c.rid == '0 || code == CM_INVALID) begin
      if (c.rid != '0) begin
        w.s.last_req = c.rid;
      end
      w = f_answer(w, RS_INVALID, PH_REJECTED, 1'b0);
    end else if (c.rid == w.s.last_req) begin
      w.res = RS_DUP;
      w.ph  = w.s.phase;
    end else begin
      w.s.last_req = c.rid;
      w.s.last_res = RS_ACCEPTED;
      w.s.phase    = PH_ACCEPTED;
      priority if (code == CM_STOP) begin
        w = f_halt_partway(w, c);
        w.s.mode_auto = 1'b0;
        w.s.latched   = 1'b1;
        w = f_answer(w, RS_ACCEPTED, PH_STOPPED, 1'b1);
      end else if (code == CM_RESET) begin
        if (c.lim_en && c.rl && c.dl) begin
          w = f_answer(w, RS_FAULT, PH_REJECTED, 1'b0);
        end else begin
          w = f_halt_partway(w, c);
          w.s.fault     = FL_NONE;
          w.s.mode_auto = 1'b0;
          w.s.latched   = 1'b1;
          w = f_answer(w, RS_ACCEPTED, PH_COMPLETED, 1'b1);
        end
      end else if (w.s.fault != FL_NONE) begin
        w = f_answer(w, RS_FAULT, PH_REJECTED, 1'b0);
      end else if (code == CM_AUTO) begin
        w.s.mode_auto = 1'b1;
        w.s.latched   = 1'b0;
        w.s.last_res  = RS_ACCEPTED;
        w.s.phase     = PH_COMPLETED;
        w = f_auto(w, c);
        w.res   = w.s.last_res;
        w.ph    = w.s.phase;
        w.taken = 1'b1;
      end else if (code == CM_MANUAL) begin
        w = f_halt_partway(w, c);
        w.s.mode_auto = 1'b0;
        w.s.latched   = 1'b0;
        w = f_answer(w, RS_ACCEPTED, PH_COMPLETED, 1'b1);
      end else if (code == CM_CAL_DEP || code == CM_CAL_RET) begin
        if (w.s.motion != MO_STOP || w.s.mode_auto) begin
          w = f_answer(w, RS_STATE, PH_REJECTED, 1'b0);
        end else begin
          w.s.latched = 1'b0;
          w = f_halt_at(w, (code == CM_CAL_DEP) ? SH_DEPLOYED : SH_RETRACTED, CF_USER);
          w = f_answer(w, RS_ACCEPTED, PH_COMPLETED, 1'b1);
        end
      end else if (w.s.mode_auto) begin
        w = f_answer(w, RS_MODE, PH_REJECTED, 1'b0);
      end else if (code == CM_RETRACT && w.s.rain_conf != RN_DRY) begin
        w = f_answer(w, RS_RAIN, PH_REJECTED, 1'b0);
      end else begin
        w.s.latched = 1'b0;
        w = f_move_to(w, (code == CM_DEPLOY) ? SH_DEPLOYED : SH_RETRACTED, c.rid, c);
        w.res   = RS_ACCEPTED;
        w.ph    = w.s.phase;
        w.taken = 1'b1;
      end
    end
    return w;
  endfunction

  function automatic wk_t f_item(st_t s, ctx_t c);
    wk_t w;
    w         = '0;
    w.s       = s;
    priority if (c.func == FN_CMD) begin
      w = f_command(w, c);
    end else begin
      if (c.func == FN_TICK) begin
        w = f_tick(w, c);
      end else if (c.func == FN_FAULT && c.fc != FL_NONE && c.fc <= FL_STORAGE) begin
        w = f_fault(w, c.fc, c);
      end
      w.res   = w.s.last_res;
      w.ph    = w.s.phase;
      w.taken = 1'b0;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_ESTA = 8'b0000_0100,
    S_DIVA = 8'b0000_1000,
    S_FLOW = 8'b0001_0000,
    S_DURB = 8'b0010_0000,
    S_DIVB = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } seq_t;

  seq_t        seq;
  st_t         st;
  ctx_t        ctx;
  wk_t         wk;

  // Configuration registers
  logic [14:0] wet_confirm_ms;
  logic [19:0] dry_confirm_ms;
  logic [12:0] dead_time_ms;
  logic [18:0] full_travel_ms;
  logic [18:0] max_runtime_ms;
  logic        use_limit_switches;

  // Captured item and precomputed compares
  logic [1:0]  it_func;
  logic [31:0] it_now;
  logic        it_wet;
  logic        it_rl;
  logic        it_dl;
  logic [3:0]  it_code;
  logic [31:0] it_rid;
  logic [2:0]  it_fc;
  logic        rain_ok;
  logic        dead_ok0;
  logic        run_ge_max;
  logic        run_ge_dur;
  logic [18:0] run19;
  logic [13:0] e0;

  // Result of the item
  logic [2:0]  res_r;
  logic [2:0]  ph_r;
  logic        taken_r;

  // Divider
  logic        div_start;
  logic [18:0] div_a;
  logic [18:0] div_den;
  logic [18:0] div_q;
  div_stat_t   div_stat;
  logic [13:0] travel_span;
  logic        need_a;
  logic [31:0] run_now;
  logic [31:0] rain_need;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wet_confirm_ms     <= 15'd2000;
      dry_confirm_ms     <= 20'd60000;
      dead_time_ms       <= 13'd500;
      full_travel_ms     <= 19'd30000;
      max_runtime_ms     <= 19'd45000;
      use_limit_switches <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WET:   wet_confirm_ms     <= pwdata[14:0];
        REG_DRY:   dry_confirm_ms     <= pwdata[19:0];
        REG_DEAD:  dead_time_ms       <= pwdata[12:0];
        REG_FULL:  full_travel_ms     <= pwdata[18:0];
        REG_MAX:   max_runtime_ms     <= pwdata[18:0];
        REG_LIMIT: use_limit_switches <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WET:   prdata = {17'd0, wet_confirm_ms};
      REG_DRY:   prdata = {12'd0, dry_confirm_ms};
      REG_DEAD:  prdata = {19'd0, dead_time_ms};
      REG_FULL:  prdata = {13'd0, full_travel_ms};
      REG_MAX:   prdata = {13'd0, max_runtime_ms};
      REG_LIMIT: prdata = {31'd0, use_limit_switches};
      default:   prdata = '0;
    endcase
  end

  // Distance between the stored start and goal; used by both divisions.
  assign travel_span = (st.pos_goal >= st.pos_start) ? st.pos_goal - st.pos_start
                                                     : st.pos_start - st.pos_goal;
  assign run_now   = it_now - st.move_start;
  assign rain_need = st.rain_cand ? {17'd0, wet_confirm_ms} : {12'd0, dry_confirm_ms};
  assign need_a    = is_driving(st.motion) && st.move_dur != '0 && !run_ge_dur;

  always_comb begin
    ctx.func       = it_func;
    ctx.now        = it_now;
    ctx.wet        = it_wet;
    ctx.rl         = it_rl;
    ctx.dl         = it_dl;
    ctx.code       = it_code;
    ctx.rid        = it_rid;
    ctx.fc         = it_fc;
    ctx.lim_en     = use_limit_switches;
    ctx.rain_ok    = rain_ok;
    ctx.dead_ok0   = dead_ok0;
    ctx.dead_zero  = dead_time_ms == '0;
    ctx.run_ge_max = run_ge_max;
    ctx.run_ge_dur = run_ge_dur;
    ctx.e0         = e0;
    ctx.full       = full_travel_ms;
  end

  assign wk = f_item(st, ctx);

  // The divider serves the running estimate (run * distance / duration) and
  // the new move duration (full travel * distance / full scale).
  assign div_start = (seq == S_ESTA && need_a) || seq == S_DURB;
  assign div_a     = (seq == S_DURB) ? full_travel_ms : run19;
  assign div_den   = (seq == S_DURB) ? 19'(POS_FULL) : st.move_dur;

  rsmc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mul_a (div_a),
    .mul_b (travel_span),
    .den   (div_den),
    .quo   (div_q),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq      <= S_IDLE;
      st       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && seq != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (seq)
        S_IDLE: begin
          if (s_tvalid) begin
            seq <= S_PREP;
          end
        end
        S_PREP: begin
          seq <= S_ESTA;
        end
        S_ESTA: begin
          seq <= need_a ? S_DIVA : S_FLOW;
        end
        S_DIVA: begin
          if (div_stat.done) begin
            seq <= S_FLOW;
          end
        end
        S_FLOW: begin
          st  <= wk.s;
          seq <= (wk.newmove && wk.dur_div) ? S_DURB : S_DONE;
        end
        S_DURB: begin
          seq <= S_DIVB;
        end
        S_DIVB: begin
          if (div_stat.done) begin
            st.move_dur <= (div_q == '0) ? 19'd1 : div_q;
            seq         <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            seq      <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (seq == S_IDLE && s_tvalid) begin
      it_func <= s_tuser;
      it_now  <= s_tdata[31:0];
      it_wet  <= s_tdata[32];
      it_rl   <= s_tdata[33];
      it_dl   <= s_tdata[34];
      it_code <= s_tdata[38:35];
      it_rid  <= s_tdata[70:39];
      it_fc   <= s_tdata[73:71];
    end
    if (seq == S_PREP) begin
      rain_ok    <= (it_now - st.rain_since) >= rain_need;
      dead_ok0   <= (it_now - st.dead_start) >= {19'd0, dead_time_ms};
      run_ge_max <= run_now >= {13'd0, max_runtime_ms};
      run_ge_dur <= run_now >= {13'd0, st.move_dur};
      run19      <= run_now[18:0];
    end
    if (seq == S_ESTA) begin
      e0 <= st.pos_goal;
    end
    if (seq == S_DIVA && div_stat.done) begin
      e0 <= (st.pos_goal >= st.pos_start) ? st.pos_start + div_q[13:0]
                                          : st.pos_start - div_q[13:0];
    end
    if (seq == S_FLOW) begin
      res_r   <= wk.res;
      ph_r    <= wk.ph;
      taken_r <= wk.taken;
    end
    if (seq == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'd0, st.latched, st.est_ok, st.pos_now, st.fault, st.rain_conf,
                  st.mode_auto, st.conf, st.shield, st.motion, taken_r, ph_r, res_r};
    end
  end

  assign s_tready = seq == S_IDLE;

endmodule

`default_nettype wire

FILE: sv/rsmc_checker.sv
// ----------------------------------------------------------------------------
// Rain shield motor controller checker
// Port-level checks on item flow and status consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rain_shield_motor_controller_assert.svh"

module rsmc_checker
  import rsmc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // The controller works on one item at a time.
  `RSMC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "accepted while busy")

  // A stalled result item holds.
  `RSMC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed")

  // The position estimate stays within full scale.
  `RSMC_ASSERT_NOW(a_pos_range, m_tvalid, m_tdata[32:19] <= POS_FULL, "position out of range")

  // A latched fault always leaves the motor stopped.
  `RSMC_ASSERT_NOW(a_fault_stop, m_tvalid && m_tdata[18:16] != FL_NONE,
    m_tdata[8:7] == MO_STOP, "motor moving under fault")

  // A taken command always reports acceptance.
  `RSMC_ASSERT_NOW(a_taken, m_tvalid && m_tdata[6], m_tdata[2:0] == RS_ACCEPTED,
    "taken command not accepted")

endmodule

bind rain_shield_motor_controller rsmc_checker u_rsmc_checker (.*);

`default_nettype wire

FILE: dv/rain_shield_motor_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rain shield motor controller testbench
// Drives tick, command and fault items into the controller and checks every
// status item against a cycle-free model of the rain debounce, the motor
// sequencing and the position estimate kept inside this bench.
// ----------------------------------------------------------------------------
module rain_shield_motor_controller_tb;
  import rsmc_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] FN_OTHER   = 2'd3;
  localparam logic [2:0] FL_PERSIST = 3'd3;
  localparam logic [3:0] CM_UNKNOWN = 4'd15;

  // Status item, highest field first so that it overlays m_tdata directly.
  typedef struct packed {
    logic [4:0]  fill;
    logic        stop;
    logic        pos_ok;
    logic [13:0] pos;
    logic [2:0]  flt;
    logic [1:0]  rain;
    logic        auto_on;
    logic [1:0]  cf;
    logic [1:0]  sh;
    logic [1:0]  mo;
    logic        taken;
    logic [2:0]  ph;
    logic [2:0]  res;
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic        wet;
    logic        rl;
    logic        dl;
    logic [3:0]  code;
    logic [31:0] rid;
    logic [2:0]  fc;
  } shield_item_t;

  typedef struct packed {
    shield_item_t it;
    logic         fixed_ok;
    status_t      fixed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk = ~clk;

  rain_shield_motor_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Status items still owed by the controller, oldest first.
  status_t owed_status_q[$];
  int      fail_cnt = 0;
  // When set, both sides run without gaps.
  logic    quiet = 1'b0;
  // Asks the receiver for one long hold-off.
  logic    hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Shadow copy of the controller: configuration and state.
  // --------------------------------------------------------------------------
  logic [14:0] cfg_wet  = 15'd2000;
  logic [19:0] cfg_dry  = 20'd60000;
  logic [12:0] cfg_dead = 13'd500;
  logic [18:0] cfg_full = 19'd30000;
  logic [18:0] cfg_max  = 19'd45000;
  logic        cfg_lim  = 1'b1;

  logic        auto_on = 0;
  logic [1:0]  rain_conf = RN_UNKNOWN;
  logic        rain_cand = 0;
  logic [31:0] rain_since = 0;
  logic [1:0]  shield = SH_UNKNOWN;
  logic [1:0]  conf = CF_UNKNOWN;
  logic [1:0]  motion = MO_STOP;
  logic [1:0]  pend = SH_UNKNOWN;
  logic [2:0]  fault = FL_NONE;
  logic        latched = 0;
  logic        est_ok = 0;
  logic [13:0] pos_now = 0, pos_start = 0, pos_goal = 0;
  logic [18:0] move_dur = 0;
  logic [31:0] move_start = 0, dead_start = 0;
  logic [31:0] motion_req = 0, last_req = 0;
  logic [2:0]  last_res = RS_IDLE;
  logic [2:0]  phase_r = PH_NONE;

  function automatic logic driving();
    return motion == MO_DEPLOY || motion == MO_RETRACT;
  endfunction

  function automatic logic own_request();
    return motion_req != 0 && motion_req == last_req;
  endfunction

  // Linear interpolation of the position while the drive runs.
  function automatic void track_position(logic [31:0] now);
    logic [31:0] run;
    logic [13:0] travel;
    logic [63:0] q;
    if (!driving()) return;
    run = now - move_start;
    if (move_dur == 0 || run >= 32'(move_dur)) begin
      pos_now = pos_goal;
    end else begin
      travel = (pos_goal >= pos_start) ? pos_goal - pos_start : pos_start - pos_goal;
      q = (64'(travel) * 64'(run)) / 64'(move_dur);
      pos_now = (pos_goal >= pos_start) ? pos_start + 14'(q) : pos_start - 14'(q);
    end
    est_ok = 1;
    conf = CF_EST;
  endfunction

  function automatic logic end_switch_hit(logic [1:0] target, logic rl, logic dl);
    if (!cfg_lim) return 0;
    return (target == SH_DEPLOYED && dl) || (target == SH_RETRACTED && rl);
  endfunction

  function automatic void stop_at_end(logic [1:0] target, logic [1:0] c);
    motion = MO_STOP;
    pend = SH_UNKNOWN;
    shield = target;
    conf = c;
    pos_now = (target == SH_DEPLOYED) ? POS_FULL : 14'd0;
    est_ok = 1;
    if (own_request()) phase_r = PH_COMPLETED;
    motion_req = 0;
  endfunction

  function automatic void stop_partway(logic [31:0] now);
    track_position(now);
    if (motion != MO_STOP) shield = SH_PARTWAY;
    motion = MO_STOP;
    pend = SH_UNKNOWN;
    motion_req = 0;
    if (!est_ok) conf = CF_UNKNOWN;
  endfunction

  function automatic void raise_fault(logic [2:0] f, logic [31:0] now);
    track_position(now);
    if (motion != MO_STOP) shield = SH_PARTWAY;
    motion = MO_STOP;
    pend = SH_UNKNOWN;
    fault = f;
    latched = 1;
    if (own_request()) phase_r = PH_FAULT;
    motion_req = 0;
  endfunction

  function automatic void head_for(logic [1:0] target, logic [31:0] now, logic rl, logic dl,
                                   logic [31:0] rid);
    logic        mine;
    logic [13:0] travel;
    logic [63:0] d;
    mine = rid != 0 && rid == last_req;
    if (target != SH_RETRACTED && target != SH_DEPLOYED) return;
    track_position(now);
    if (end_switch_hit(target, rl, dl)) begin
      stop_at_end(target, CF_LIMIT);
      if (mine) phase_r = PH_COMPLETED;
      return;
    end
    if (motion == MO_STOP && shield == target) begin
      if (mine) phase_r = PH_COMPLETED;
      return;
    end
    if ((motion == MO_DEPLOY && target == SH_DEPLOYED) ||
        (motion == MO_RETRACT && target == SH_RETRACTED)) begin
      motion_req = rid;
      if (mine) phase_r = PH_STARTED;
      return;
    end
    if (motion == MO_DEAD && pend == target) begin
      if (rid != 0) motion_req = rid;
      return;
    end
    pend = target;
    motion_req = rid;
    pos_start = est_ok ? pos_now : ((target == SH_DEPLOYED) ? 14'd0 : POS_FULL);
    pos_goal = (target == SH_DEPLOYED) ? POS_FULL : 14'd0;
    if (est_ok) begin
      travel = (pos_goal >= pos_start) ? pos_goal - pos_start : pos_start - pos_goal;
      d = (64'(cfg_full) * 64'(travel)) / 64'(POS_FULL);
      move_dur = 19'(d);
    end else begin
      move_dur = cfg_full;
    end
    if (move_dur == 0) move_dur = 19'd1;
    motion = MO_DEAD;
    dead_start = now;
    shield = SH_PARTWAY;
    conf = est_ok ? CF_EST : CF_UNKNOWN;
  endfunction

  // Dead time expiry, end switches, travel time and runtime limit.
  function automatic void advance_motor(logic [31:0] now, logic rl, logic dl);
    logic [1:0]  target;
    logic [31:0] run;
    if (fault != FL_NONE) return;
    if (cfg_lim && rl && dl) begin
      raise_fault(FL_CONFLICT, now);
      return;
    end
    if (motion == MO_DEAD) begin
      if (end_switch_hit(pend, rl, dl)) begin
        stop_at_end(pend, CF_LIMIT);
      end else if (now - dead_start >= 32'(cfg_dead)) begin
        if (pend == SH_RETRACTED || pend == SH_DEPLOYED) begin
          motion = (pend == SH_DEPLOYED) ? MO_DEPLOY : MO_RETRACT;
          move_start = now;
          shield = SH_PARTWAY;
          if (own_request()) phase_r = PH_STARTED;
        end
      end
      return;
    end
    if (!driving()) return;
    track_position(now);
    target = (motion == MO_DEPLOY) ? SH_DEPLOYED : SH_RETRACTED;
    if (end_switch_hit(target, rl, dl)) begin
      stop_at_end(target, CF_LIMIT);
      return;
    end
    run = now - move_start;
    if (run >= 32'(cfg_max)) raise_fault(FL_TIMEOUT, now);
    else if (!cfg_lim && run >= 32'(move_dur)) stop_at_end(target, CF_EST);
  endfunction

  function automatic void follow_rain(logic [31:0] now, logic rl, logic dl);
    if (!auto_on || latched || fault != FL_NONE) return;
    if (rain_conf == RN_WET) begin
      if (shield != SH_DEPLOYED || motion == MO_RETRACT ||
          (motion == MO_DEAD && pend == SH_RETRACTED))
        head_for(SH_DEPLOYED, now, rl, dl, 0);
    end else if (rain_conf == RN_DRY && est_ok && shield != SH_RETRACTED) begin
      head_for(SH_RETRACTED, now, rl, dl, 0);
    end
  endfunction

  function automatic void take_tick(logic [31:0] now, logic wet, logic rl, logic dl);
    logic [31:0] need;
    logic        going_in;
    if (wet != rain_cand) begin
      rain_cand = wet;
      rain_since = now;
    end else begin
      need = rain_cand ? 32'(cfg_wet) : 32'(cfg_dry);
      if (now - rain_since >= need) rain_conf = rain_cand ? RN_WET : RN_DRY;
    end
    going_in = motion == MO_RETRACT || (motion == MO_DEAD && pend == SH_RETRACTED);
    // Rain that turns wet while retracting sends the shield back out.
    if (rain_conf == RN_WET && going_in) begin
      if (own_request()) phase_r = PH_STOPPED;
      head_for(SH_DEPLOYED, now, rl, dl, 0);
    end
    advance_motor(now, rl, dl);
    follow_rain(now, rl, dl);
  endfunction

  function automatic void reply(logic [2:0] res, logic [2:0] ph, output logic [2:0] r,
                                output logic [2:0] p);
    last_res = res;
    phase_r = ph;
    r = res;
    p = ph;
  endfunction

  function automatic logic take_command(logic [3:0] code_in, logic [31:0] rid, logic [31:0] now,
                                        logic rl, logic dl, output logic [2:0] r,
                                        output logic [2:0] p);
    logic [3:0] code;
    code = (code_in > CM_CAL_RET) ? CM_INVALID : code_in;
    if (rid == 0 || code == CM_INVALID) begin
      if (rid != 0) last_req = rid;
      reply(RS_INVALID, PH_REJECTED, r, p);
      return 0;
    end
    if (rid == last_req) begin
      r = RS_DUP;
      p = phase_r;
      return 0;
    end
    last_req = rid;
    last_res = RS_ACCEPTED;
    phase_r = PH_ACCEPTED;
    if (code == CM_STOP) begin
      stop_partway(now);
      auto_on = 0;
      latched = 1;
      reply(RS_ACCEPTED, PH_STOPPED, r, p);
      return 1;
    end
    if (code == CM_RESET) begin
      if (cfg_lim && rl && dl) begin
        reply(RS_FAULT, PH_REJECTED, r, p);
        return 0;
      end
      stop_partway(now);
      fault = FL_NONE;
      auto_on = 0;
      latched = 1;
      reply(RS_ACCEPTED, PH_COMPLETED, r, p);
      return 1;
    end
    if (fault != FL_NONE) begin
      reply(RS_FAULT, PH_REJECTED, r, p);
      return 0;
    end
    if (code == CM_AUTO) begin
      auto_on = 1;
      latched = 0;
      last_res = RS_ACCEPTED;
      phase_r = PH_COMPLETED;
      follow_rain(now, rl, dl);
      r = last_res;
      p = phase_r;
      return 1;
    end
    if (code == CM_MANUAL) begin
      stop_partway(now);
      auto_on = 0;
      latched = 0;
      reply(RS_ACCEPTED, PH_COMPLETED, r, p);
      return 1;
    end
    if (code == CM_CAL_DEP || code == CM_CAL_RET) begin
      if (motion != MO_STOP || auto_on) begin
        reply(RS_STATE, PH_REJECTED, r, p);
        return 0;
      end
      latched = 0;
      stop_at_end((code == CM_CAL_DEP) ? SH_DEPLOYED : SH_RETRACTED, CF_USER);
      reply(RS_ACCEPTED, PH_COMPLETED, r, p);
      return 1;
    end
    if (auto_on) begin
      reply(RS_MODE, PH_REJECTED, r, p);
      return 0;
    end
    // Manual retract is only allowed once dry weather is confirmed.
    if (code == CM_RETRACT && rain_conf != RN_DRY) begin
      reply(RS_RAIN, PH_REJECTED, r, p);
      return 0;
    end
    latched = 0;
    head_for((code == CM_DEPLOY) ? SH_DEPLOYED : SH_RETRACTED, now, rl, dl, rid);
    r = RS_ACCEPTED;
    p = phase_r;
    return 1;
  endfunction

  // Works out the status item that one accepted input item produces.
  function automatic status_t next_status(shield_item_t it);
    status_t s;
    logic [2:0] r, p;
    logic tk;
    r = last_res;
    p = phase_r;
    tk = 0;
    case (it.func)
      FN_TICK: begin
        take_tick(it.now, it.wet, it.rl, it.dl);
        r = last_res;
        p = phase_r;
      end
      FN_CMD: tk = take_command(it.code, it.rid, it.now, it.rl, it.dl, r, p);
      FN_FAULT: begin
        if (it.fc >= FL_TIMEOUT && it.fc <= FL_STORAGE) raise_fault(it.fc, it.now);
        r = last_res;
        p = phase_r;
      end
      default: ;
    endcase
    s = '0;
    s.res = r;
    s.ph = p;
    s.taken = tk;
    s.mo = motion;
    s.sh = shield;
    s.cf = conf;
    s.auto_on = auto_on;
    s.rain = rain_conf;
    s.flt = fault;
    s.pos = pos_now;
    s.pos_ok = est_ok;
    s.stop = latched;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Bus tasks.
  // --------------------------------------------------------------------------

  // Setup cycle, access cycle, then the shadow register takes the same value.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WET:   cfg_wet = val[14:0];
      REG_DRY:   cfg_dry = val[19:0];
      REG_DEAD:  cfg_dead = val[12:0];
      REG_FULL:  cfg_full = val[18:0];
      REG_MAX:   cfg_max = val[18:0];
      REG_LIMIT: cfg_lim = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(int wet, int dry, int dead, int full, int mx, int lim);
    write_reg(REG_WET, wet);
    write_reg(REG_DRY, dry);
    write_reg(REG_DEAD, dead);
    write_reg(REG_FULL, full);
    write_reg(REG_MAX, mx);
    write_reg(REG_LIMIT, lim);
  endtask

  // Offers one item after a random gap; the expected status is queued on
  // acceptance. Valid stays high across back-to-back items.
  task automatic send_item(shield_item_t it, logic fixed_ok, status_t fixed);
    int gap;
    status_t want;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.func;
    s_tdata <= {6'b0, it.fc, it.rid, it.code, it.dl, it.rl, it.wet, it.now};
    do @(posedge clk); while (!s_tready);
    want = next_status(it);
    if (fixed_ok) want = fixed;
    owed_status_q.push_back(want);
  endtask

  // Lets every owed status come back, then leaves the block some spare time.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (owed_status_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus. Time moves forward in steps scaled to the current
  // configuration, rain changes slowly, and the end switches close mostly
  // while the shield is actually heading for them.
  // --------------------------------------------------------------------------
  logic [31:0] t_now = 0;
  logic        rain_level = 0;

  function automatic shield_item_t random_item(int span);
    shield_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) t_now += $urandom_range(0, span / 10);
    else if (r < 95) t_now += $urandom_range(0, span);
    else t_now += $urandom_range(0, span * 4);
    if ($urandom_range(0, 99) < 4) rain_level = !rain_level;
    it.now = t_now;
    it.wet = ($urandom_range(0, 99) < 2) ? !rain_level : rain_level;
    it.rl = ($urandom_range(0, 99) < 2) ||
            (motion == MO_RETRACT && $urandom_range(0, 99) < 15);
    it.dl = ($urandom_range(0, 99) < 2) ||
            (motion == MO_DEPLOY && $urandom_range(0, 99) < 15);
    r = $urandom_range(0, 99);
    if (r < 78) it.func = FN_TICK;
    else if (r < 95) it.func = FN_CMD;
    else if (r < 98) it.func = FN_FAULT;
    else it.func = FN_OTHER;
    it.code = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(CM_AUTO, CM_CAL_RET));
    r = $urandom_range(0, 99);
    if (r < 6) it.rid = last_req;
    else if (r < 9) it.rid = 0;
    else it.rid = $urandom;
    it.fc = 3'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic random_run(int count, int span);
    for (int i = 0; i < count; i++) begin
      quiet = (i % 120) < 25;
      send_item(random_item(span), 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  function automatic status_t fixed_reply(logic [2:0] res, logic [2:0] ph);
    status_t s;
    s = '0;
    s.res = res;
    s.ph = ph;
    return s;
  endfunction

  dir_row_t dir_rows[$];

  task automatic add_row(logic [1:0] func, logic [31:0] now, logic wet, logic rl, logic dl,
                         logic [3:0] code, logic [31:0] rid, logic [2:0] fc,
                         logic fixed_ok = 1'b0, status_t fixed = '0);
    dir_row_t row;
    row.it = '{func, now, wet, rl, dl, code, rid, fc};
    row.fixed_ok = fixed_ok;
    row.fixed = fixed;
    dir_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request, field checks.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  initial begin
    int stall;
    status_t got, want;
    wait (!rst);
    forever begin
      if (hold_req) begin
        // Long hold-off so the output register fills and the input stalls.
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 16);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = status_t'(m_tdata);
      if (owed_status_q.size() == 0) begin
        $error("status item arrived with nothing expected");
        fail_cnt++;
      end else begin
        want = owed_status_q.pop_front();
        check_field("cmd_result", want.res, got.res);
        check_field("cmd_phase", want.ph, got.ph);
        check_field("cmd_taken", want.taken, got.taken);
        check_field("motion_state", want.mo, got.mo);
        check_field("shield_state", want.sh, got.sh);
        check_field("confidence", want.cf, got.cf);
        check_field("auto_mode", want.auto_on, got.auto_on);
        check_field("rain_state", want.rain, got.rain);
        check_field("fault_state", want.flt, got.flt);
        check_field("position", want.pos, got.pos);
        check_field("position_valid", want.pos_ok, got.pos_ok);
        check_field("stop_latched", want.stop, got.stop);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Directed part, with the register defaults. The first rows only touch
    // the reply codes, so their status can be written out in full.
    add_row(FN_TICK, 0, 0, 0, 0, CM_INVALID, 0, FL_NONE, 1'b1, '0);
    add_row(FN_CMD, 10, 0, 0, 0, CM_DEPLOY, 0, FL_NONE,
            1'b1, fixed_reply(RS_INVALID, PH_REJECTED));
    add_row(FN_CMD, 20, 0, 0, 0, CM_INVALID, 5, FL_NONE,
            1'b1, fixed_reply(RS_INVALID, PH_REJECTED));
    add_row(FN_CMD, 30, 0, 0, 0, CM_STOP, 5, FL_NONE,
            1'b1, fixed_reply(RS_DUP, PH_REJECTED));
    // Unknown fault code raises nothing.
    add_row(FN_FAULT, 40, 0, 0, 0, CM_INVALID, 0, 3'd7,
            1'b1, fixed_reply(RS_INVALID, PH_REJECTED));
    add_row(FN_CMD, 50, 0, 0, 0, CM_UNKNOWN, 6, FL_NONE);
    add_row(FN_CMD, 60, 0, 0, 0, CM_CAL_RET, 7, FL_NONE);
    add_row(FN_TICK, 100, 1, 0, 0, CM_INVALID, 0, FL_NONE);
    add_row(FN_TICK, 2200, 1, 0, 0, CM_INVALID, 0, FL_NONE);
    add_row(FN_CMD, 2300, 1, 0, 0, CM_RETRACT, 8, FL_NONE);
    add_row(FN_CMD, 2300, 1, 0, 0, CM_DEPLOY, 9, FL_NONE);
    add_row(FN_TICK, 2800, 1, 0, 0, CM_INVALID, 0, FL_NONE);
    add_row(FN_TICK, 12000, 1, 0, 0, CM_INVALID, 0, FL_NONE);
    add_row(FN_TICK, 20000, 1, 0, 1, CM_INVALID, 0, FL_NONE);
    add_row(FN_TICK, 20100, 1, 1, 1, CM_INVALID, 0, FL_NONE);
    add_row(FN_CMD, 20200, 1, 0, 0, CM_DEPLOY, 10, FL_NONE);
    add_row(FN_CMD, 20300, 1, 1, 1, CM_RESET, 11, FL_NONE);
    add_row(FN_CMD, 20400, 1, 0, 0, CM_RESET, 12, FL_NONE);
    add_row(FN_CMD, 20500, 1, 0, 0, CM_AUTO, 13, FL_NONE);
    add_row(FN_CMD, 20600, 1, 0, 0, CM_CAL_DEP, 14, FL_NONE);
    add_row(FN_CMD, 20700, 1, 0, 0, CM_MANUAL, 15, FL_NONE);
    add_row(FN_FAULT, 20800, 1, 0, 0, CM_INVALID, 0, FL_STORAGE);
    add_row(FN_OTHER, 20900, 1, 0, 0, CM_INVALID, 0, FL_PERSIST);
    add_row(FN_CMD, 21000, 0, 0, 0, CM_RESET, 32'hFFFF_FFFF, FL_NONE);
    add_row(FN_TICK, 32'hFFFF_FFFF, 1, 1, 1, 4'hF, 32'hFFFF_FFFF, 3'd7);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].fixed_ok, dir_rows[i].fixed);
    drain();

    // Defaults, with the clock far from zero.
    t_now = $urandom;
    random_run(270, 20000);
    drain();

    // Smallest settings; the receiver holds off once meanwhile.
    write_all(250, 1000, 100, 1000, 1000, 1);
    hold_req = 1'b1;
    random_run(270, 1500);
    drain();

    // Travel-time stops without end switches.
    write_all(300, 1200, 150, 1000, 360000, 0);
    random_run(270, 1500);
    drain();

    // Largest settings, with the time counter about to wrap.
    write_all(30000, 600000, 5000, 300000, 360000, 1);
    t_now = 32'hFFF0_0000;
    random_run(270, 200000);
    drain();

    // Random settings; the switch enable gets noise in its upper bits.
    write_all($urandom_range(250, 30000), $urandom_range(1000, 600000),
              $urandom_range(100, 5000), $urandom_range(1000, 300000),
              $urandom_range(1000, 360000), $urandom);
    random_run(270, 20000);
    drain();

    // Runtime shorter than the travel, and no dead time: timeouts.
    write_all(0, 1000, 0, 300000, 1000, 0);
    hold_req = 1'b1;
    random_run(270, 3000);
    drain();

    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
